// ----- sv/single_float_adder_assert.svh -----
// assertion macros for the float adder checker
`ifndef SINGLE_FLOAT_ADDER_ASSERT_SVH
`define SINGLE_FLOAT_ADDER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SFA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define SFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- sv/sfa_pkg.sv -----
// shared types and constants for the float adder
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DENORMAL = 3'd1;
	localparam logic [2:0] ST_INF      = 3'd2;
	localparam logic [2:0] ST_NAN      = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	localparam logic [23:0] HIDDEN_BIT = 24'h800000;
	localparam logic [22:0] FRAC_MASK  = 23'h7fffff;
	localparam logic [23:0] SIG_MASK   = 24'hffffff;

	typedef struct packed {
		logic [31:0] a_bits;
		logic [31:0] b_bits;
	} sfa_in_t;

	typedef struct packed {
		logic [31:0] sum_bits;
		logic [2:0]  status;
	} sfa_out_t;

	// aligned operands after the first stage
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic [2:0]  special_status;
		logic        sl;
		logic        ss;
		logic [7:0]  el;
		logic [23:0] ml;
		logic [23:0] ms;
	} sfa_align_t;

	// raw sum after the second stage
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic [2:0]  special_status;
		logic        rs;
		logic [7:0]  el;
		logic [24:0] mag;
	} sfa_sum_t;
endpackage
`default_nettype wire

// ----- sv/sfa_align.sv -----
// stage 1 logic: unpack, special cases, operand swap and alignment shift
`timescale 1ns / 1ps
`default_nettype none
module sfa_align import sfa_pkg::*; (
	input  wire sfa_in_t    din,
	output sfa_align_t      dout
);
	logic        sa, sb;
	logic [7:0]  ea, eb, gap;
	logic [22:0] fa, fb;
	logic [23:0] ms_raw;

	always_comb begin
		sa = din.a_bits[31];
		ea = din.a_bits[30:23];
		fa = din.a_bits[22:0];
		sb = din.b_bits[31];
		eb = din.b_bits[30:23];
		fb = din.b_bits[22:0];
		dout = '0;
		dout.special = 1'b1;
		if (ea == 8'd0 && fa == 23'd0) begin
			dout.special_bits = din.b_bits;
		end else if (eb == 8'd0 && fb == 23'd0) begin
			dout.special_bits = din.a_bits;
		end else if (ea == 8'd0 || eb == 8'd0) begin
			dout.special_status = ST_DENORMAL;
		end else if ((ea == 8'hff && fa == 23'd0) || (eb == 8'hff && fb == 23'd0)) begin
			dout.special_status = ST_INF;
		end else if (ea == 8'hff || eb == 8'hff) begin
			dout.special_status = ST_NAN;
		end else begin
			dout.special = 1'b0;
		end
		if (ea >= eb) begin
			dout.sl = sa; dout.el = ea; dout.ml = {1'b1, fa};
			dout.ss = sb; ms_raw = {1'b1, fb}; gap = ea - eb;
		end else begin
			dout.sl = sb; dout.el = eb; dout.ml = {1'b1, fb};
			dout.ss = sa; ms_raw = {1'b1, fa}; gap = eb - ea;
		end
		dout.ms = (gap >= 8'd25) ? 24'd0 : (ms_raw >> gap[4:0]);
	end
endmodule
`default_nettype wire

// ----- sv/sfa_addsub.sv -----
// stage 2 logic: signed significand add or subtract
`timescale 1ns / 1ps
`default_nettype none
module sfa_addsub import sfa_pkg::*; (
	input  wire sfa_align_t din,
	output sfa_sum_t        dout
);
	always_comb begin
		dout.special        = din.special;
		dout.special_bits   = din.special_bits;
		dout.special_status = din.special_status;
		dout.el             = din.el;
		if (din.sl == din.ss) begin
			dout.mag = {1'b0, din.ml} + {1'b0, din.ms};
			dout.rs  = din.sl;
		end else if (din.ml >= din.ms) begin
			dout.mag = {1'b0, din.ml - din.ms};
			dout.rs  = din.sl;
		end else begin
			dout.mag = {1'b0, din.ms - din.ml};
			dout.rs  = din.ss;
		end
	end
endmodule
`default_nettype wire

// ----- sv/sfa_norm.sv -----
// stage 3 logic: leading-one normalize, overflow and underflow
`timescale 1ns / 1ps
`default_nettype none
module sfa_norm import sfa_pkg::*; (
	input  wire sfa_sum_t din,
	output sfa_out_t      dout
);
	logic [4:0]  lz;
	logic [23:0] sig;
	logic [9:0]  e;

	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (din.mag[i]) lz = 5'(23 - i);
		end
		if (din.mag[24]) begin
			sig = din.mag[24:1];
			e   = {2'b00, din.el} + 10'd1;
		end else begin
			sig = din.mag[23:0] << lz;
			e   = {2'b00, din.el} - {5'd0, lz};
		end
		dout.status = ST_OK;
		if (din.special) begin
			dout.sum_bits = din.special_bits;
			dout.status   = din.special_status;
		end else if (din.mag == 25'd0) begin
			dout.sum_bits = 32'd0;
		end else if (!e[9] && e >= 10'd255) begin
			dout.sum_bits = {din.rs, 31'h7f800000};
			dout.status   = ST_OVERFLOW;
		end else if (e[9] || e == 10'd0) begin
			dout.sum_bits = 32'd0;
		end else begin
			dout.sum_bits = {din.rs, e[7:0], sig[22:0] & FRAC_MASK};
		end
	end
endmodule
`default_nettype wire

// ----- sv/single_float_adder.sv -----
// top level of the pipelined single-precision float adder
// pipeline: the accepted input is registered in stage 1, then stage 2, then stage 3, which drives out_data
// throughput: one transaction per cycle; stall holds the whole pipeline,
// bubbles are filled even under stall
// reset: arst_n asynchronously clears all stage valid bits
`timescale 1ns / 1ps
`default_nettype none
module single_float_adder import sfa_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire sfa_in_t in_data,
	output logic       out_valid,
	input  wire        out_stall,
	output sfa_out_t   out_data
);
	sfa_align_t a_c, a_s1;
	sfa_sum_t   s_c, s_s2;
	sfa_out_t   n_c, n_s3;
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	sfa_align  u_align  (.din(in_data), .dout(a_c));
	sfa_addsub u_addsub (.din(a_s1),    .dout(s_c));
	sfa_norm   u_norm   (.din(s_s2),    .dout(n_c));

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall  = !en1;
	assign out_valid = v_s3;
	assign out_data  = n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) a_s1 <= a_c;
		if (en2) s_s2 <= s_c;
		if (en3) n_s3 <= n_c;
	end
endmodule
`default_nettype wire

// ----- sv/sfa_checker.sv -----
// port-level checker for the float adder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "single_float_adder_assert.svh"
module sfa_checker import sfa_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire in_stall,
	input wire out_valid,
	input wire out_stall,
	input wire sfa_out_t out_data
);
	logic ovf_v;

	assign ovf_v = out_valid && out_data.status == ST_OVERFLOW;

	`SFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	`SFA_ASSERT_IMP(a_stat_range, out_valid, out_data.status <= ST_OVERFLOW)
	`SFA_ASSERT_IMP(a_no_stall_free, !out_stall, !in_stall)
	`SFA_ASSERT_IMP(a_ovf_inf, ovf_v, out_data.sum_bits[30:0] == 31'h7f800000)
endmodule
bind single_float_adder sfa_checker u_sfa_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the pipelined single-precision float adder
`timescale 1ns / 1ps
module tb_top;
	import sfa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sfa_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sfa_out_t out_data;

	sfa_out_t sums_pending[$];
	int errors = 0;
	int rx_gap = 0;
	bit hold_rx = 1'b0;
	bit rx_noisy = 1'b1;

	single_float_adder i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("[single_float_adder] ERROR");
		$finish;
	end

	// truncating float add with status
	function automatic sfa_out_t fadd_trunc(logic [31:0] a, logic [31:0] b);
		sfa_out_t r;
		logic sl, ss, rs;
		logic [7:0] el, es, ea, eb;
		logic [23:0] ml, ms;
		logic [24:0] mag;
		int e;
		int gap;
		r = '0;
		ea = a[30:23];
		eb = b[30:23];
		if (a[30:0] == 0) r.sum_bits = b;
		else if (b[30:0] == 0) r.sum_bits = a;
		else if (ea == 0 || eb == 0) r.status = ST_DENORMAL;
		else if ((ea == 8'hff && a[22:0] == 0) || (eb == 8'hff && b[22:0] == 0))
			r.status = ST_INF;
		else if (ea == 8'hff || eb == 8'hff) r.status = ST_NAN;
		else begin
			if (ea >= eb) begin
				sl = a[31]; el = ea; ml = {1'b1, a[22:0]};
				ss = b[31]; es = eb; ms = {1'b1, b[22:0]};
			end else begin
				sl = b[31]; el = eb; ml = {1'b1, b[22:0]};
				ss = a[31]; es = ea; ms = {1'b1, a[22:0]};
			end
			gap = int'(el - es);
			ms = (gap >= 25) ? 24'd0 : ms >> gap;
			if (sl == ss) begin
				mag = {1'b0, ml} + {1'b0, ms}; rs = sl;
			end else if (ml >= ms) begin
				mag = {1'b0, ml - ms}; rs = sl;
			end else begin
				mag = {1'b0, ms - ml}; rs = ss;
			end
			if (mag != 0) begin
				e = int'(el);
				if (mag[24]) begin
					mag = mag >> 1;
					e++;
				end else begin
					while (!mag[23]) begin
						mag = mag << 1;
						e--;
					end
				end
				if (e >= 255) begin
					r.sum_bits = {rs, 31'h7f800000};
					r.status = ST_OVERFLOW;
				end else if (e > 0) begin
					r.sum_bits = {rs, e[7:0], mag[22:0]};
				end
			end
		end
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// receiver side stall and result check
	always @(negedge clk) begin
		if (hold_rx) out_stall <= 1'b1;
		else if (rx_noisy && rx_gap > 0) begin
			out_stall <= 1'b1;
			rx_gap--;
		end else begin
			out_stall <= 1'b0;
			if (rx_noisy && $urandom_range(0, 2) == 0) rx_gap = gap_len();
		end
	end

	always @(posedge clk) begin
		sfa_out_t exp_sum;
		if (arst_n && out_valid && !out_stall) begin
			if (sums_pending.size() == 0) begin
				$error("unexpected transaction %h", out_data);
				errors++;
			end else begin
				exp_sum = sums_pending.pop_front();
				if (out_data.sum_bits !== exp_sum.sum_bits) begin
					$error("sum_bits exp %h got %h", exp_sum.sum_bits, out_data.sum_bits);
					errors++;
				end
				if (out_data.status !== exp_sum.status) begin
					$error("status exp %0d got %0d", exp_sum.status, out_data.status);
					errors++;
				end
			end
		end
	end

	task automatic send_pair(logic [31:0] a, logic [31:0] b, bit gaps);
		int g;
		in_data <= '{a_bits: a, b_bits: b};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sums_pending.push_back(fadd_trunc(a, b));
		@(negedge clk);
		if (gaps) begin
			g = gap_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sums_pending.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_float();
		logic [31:0] x;
		int k;
		x = $urandom;
		k = $urandom_range(0, 19);
		if (k == 0) x[30:23] = 8'h00;
		else if (k == 1) x[30:23] = 8'hff;
		else if (k == 2) x[30:0] = 31'd0;
		else if (k == 3) x[30:23] = 8'($urandom_range(250, 254));
		else if (k == 4) x[30:23] = 8'($urandom_range(1, 4));
		else if (k < 12) x[30:23] = 8'($urandom_range(110, 140));
		return x;
	endfunction

	task automatic test_special_cases();
		send_pair(32'h0000_0000, 32'h7fc0_0001, 0);
		send_pair(32'h8000_0000, 32'h0000_0001, 0);
		send_pair(32'h3f80_0000, 32'h8000_0000, 0);
		send_pair(32'h0000_0000, 32'h8000_0000, 0);
		send_pair(32'h0040_0000, 32'h3f80_0000, 0);
		send_pair(32'h3f80_0000, 32'h807f_ffff, 0);
		send_pair(32'h7f80_0000, 32'h3f80_0000, 0);
		send_pair(32'h3f80_0000, 32'hff80_0000, 0);
		send_pair(32'h7fff_ffff, 32'h3f80_0000, 0);
		send_pair(32'h3f80_0000, 32'hff80_0001, 0);
		send_pair(32'h7f80_0001, 32'hff80_0000, 0);
		drain();
	endtask

	task automatic test_arithmetic();
		send_pair(32'h3f80_0000, 32'h3f80_0000, 0);
		send_pair(32'h3f80_0000, 32'hbf80_0000, 0);
		send_pair(32'h3f80_0000, 32'hbf7f_ffff, 0);
		send_pair(32'h4b80_0000, 32'h3f80_0000, 0);
		send_pair(32'h4c00_0000, 32'h3f80_0000, 0);
		send_pair(32'h7f7f_ffff, 32'h7f7f_ffff, 0);
		send_pair(32'hff7f_ffff, 32'hff00_0000, 0);
		send_pair(32'h0080_0001, 32'h8080_0000, 0);
		send_pair(32'h00ff_ffff, 32'h8080_0000, 0);
		send_pair(32'hbfc0_0000, 32'h3f80_0000, 0);
		send_pair(32'h3fff_ffff, 32'h3fff_ffff, 0);
		send_pair(32'hc000_0000, 32'h3fff_ffff, 0);
		drain();
	endtask

	task automatic test_random();
		logic [31:0] a, b;
		repeat (380) begin
			a = rand_float();
			b = rand_float();
			if ($urandom_range(0, 4) == 0) b = {~a[31], a[30:23], b[22:0]};
			send_pair(a, b, ($urandom_range(0, 3) != 0));
		end
		drain();
	endtask

	task automatic test_backpressure();
		rx_noisy = 1'b0;
		fork
			begin
				hold_rx = 1'b1;
				repeat (40) @(negedge clk);
				hold_rx = 1'b0;
			end
			repeat (30) send_pair(rand_float(), rand_float(), 0);
		join
		drain();
		rx_noisy = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_special_cases();
		test_arithmetic();
		test_random();
		test_backpressure();
		if (errors == 0) $display("[single_float_adder] OK");
		else $display("[single_float_adder] ERROR");
		$finish;
	end
endmodule
